// File: rtl/core/stte_pkg.sv
// Shared types, constants and helpers for the swing touchdown tau extension block.
// No dependencies; every other file in rtl/core imports this package.

package stte_pkg;

    localparam logic [16:0] Q_ONE          = 17'd65536;
    localparam logic [16:0] EXT_CONF_FLOOR = 17'd22938;

    // Target tau numerator is 92*65536 + 50 + 6*conf; divide by 100 via reciprocal.
    localparam logic [22:0] TGT_BASE   = 23'd6029362;
    localparam logic [23:0] TGT_RECIP  = 24'd10737419;
    localparam int          TGT_SHIFT  = 30;

    localparam int QUO_W  = 16;
    localparam int XS_W   = 33;
    localparam int REM_W  = 34;

    localparam logic [16:0] MIN_TRUST_RST = 17'd22938;
    localparam logic [15:0] LATE_TAU_RST  = 16'd56361;
    localparam logic [15:0] MAX_EXT_RST   = 16'd14000;

    localparam logic [1:0] CFG_MIN_TRUST = 2'd0;
    localparam logic [1:0] CFG_LATE_TAU  = 2'd1;
    localparam logic [1:0] CFG_MAX_EXT   = 2'd2;

    typedef enum logic [1:0]
    {
        PH_SEARCH = 2'd0,
        PH_EXPECT = 2'd1,
        PH_CAND   = 2'd2,
        PH_STANCE = 2'd3
    } phase_t;

    typedef enum logic [1:0]
    {
        MODE_PASS    = 2'd0,
        MODE_CONTACT = 2'd1,
        MODE_TOUCH   = 2'd2
    } mode_t;

    typedef struct packed
    {
        mode_t       mode;
        logic [16:0] tau_c;
        logic [22:0] tgt_num;
        logic [16:0] ramp_len;
        logic [16:0] weight;
    } front_t;

    // Length of the extension ramp in Q1.16, never zero.
    function automatic logic [16:0] calc_span(input logic [15:0] late_tau);
        calc_span = Q_ONE - {1'b0, late_tau};
    endfunction

endpackage

// File: rtl/core/stte_front.sv
// Decode stage: clamps tau, qualifies trust and phase, picks ramp distance and weight.
// Depends on stte_pkg.

module stte_front
    import stte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        swing_active,
    input  logic        raw_contact,
    input  logic        state_valid,
    input  logic        has_diagnostics,
    input  logic        reset_requested,
    input  logic [16:0] fusion_trust,
    input  logic        has_fusion_record,
    input  logic [1:0]  contact_phase,
    input  logic [16:0] contact_confidence,
    input  logic signed [19:0] tau_in,
    input  logic [16:0] min_trust,
    input  logic [15:0] late_tau,
    output logic        vld,
    output front_t      front
);

    logic        vld_reg;
    front_t      front_reg;
    front_t      front_next;

    logic        tau_neg;
    logic [18:0] tau_mag;
    logic        late_hit;
    logic [18:0] diff;
    logic [16:0] span;
    logic [16:0] ramp_dist;
    logic [16:0] conf_sat;
    logic [16:0] touch_w;
    phase_t      phase;
    logic        trusted;
    logic        active;

    always_comb
    begin
        tau_neg  = tau_in[19];
        tau_mag  = tau_in[18:0];
        span     = calc_span(late_tau);
        late_hit = !tau_neg && (tau_mag >= {3'b000, late_tau});
        diff     = tau_mag - {3'b000, late_tau};
        ramp_dist = late_hit ? ((diff > {2'b00, span}) ? span : diff[16:0]) : 17'd0;

        conf_sat = (contact_confidence > Q_ONE) ? Q_ONE : contact_confidence;
        touch_w  = (conf_sat > EXT_CONF_FLOOR) ? conf_sat : EXT_CONF_FLOOR;
        phase    = has_fusion_record ? phase_t'(contact_phase) : PH_SEARCH;

        trusted = state_valid &&
                  (!has_diagnostics || (!reset_requested && (fusion_trust >= min_trust)));
        active  = swing_active && trusted;

        if (tau_neg)
            front_next.tau_c = 17'd0;
        else if (tau_mag > {2'b00, Q_ONE})
            front_next.tau_c = Q_ONE;
        else
            front_next.tau_c = tau_mag[16:0];

        front_next.tgt_num = TGT_BASE + ({6'd0, conf_sat} << 2) + ({6'd0, conf_sat} << 1);

        // zero distance drives the extension to zero downstream
        front_next.mode     = MODE_PASS;
        front_next.ramp_len = 17'd0;
        front_next.weight   = Q_ONE;
        if (active)
        begin
            if (raw_contact)
                front_next.mode = MODE_CONTACT;
            else
            begin
                case (phase)
                    PH_EXPECT, PH_CAND:
                    begin
                        front_next.mode     = MODE_TOUCH;
                        front_next.ramp_len = ramp_dist;
                        front_next.weight   = touch_w;
                    end
                    PH_SEARCH:
                    begin
                        front_next.ramp_len = ramp_dist;
                    end
                    default:
                    begin
                        front_next.mode = MODE_PASS;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (req_valid)
            front_reg <= front_next;
    end

    assign vld   = vld_reg;
    assign front = front_reg;

endmodule

// File: rtl/core/stte_scale.sv
// Two multiply stages: target tau by reciprocal, ramp product, tau selection.
// Depends on stte_pkg.

module stte_scale
    import stte_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_vld,
    input  front_t            front,
    input  logic [15:0]       max_ext,
    output logic              vld,
    output logic [16:0]       tau_out,
    output logic [XS_W-1:0]   xs,
    output logic              occupied
);

    // stage B
    logic        b_vld_reg;
    mode_t       b_mode_reg;
    logic [16:0] b_tau_reg;
    logic [16:0] b_target_reg;
    logic [32:0] b_prod_reg;
    logic [16:0] b_weight_reg;
    logic [46:0] tgt_prod;
    logic [32:0] ramp_prod;

    // stage C
    logic            c_vld_reg;
    logic [16:0]     c_tau_reg;
    logic [16:0]     c_tau_next;
    logic [XS_W-1:0] c_xs_reg;
    logic [49:0]     x_prod;

    assign tgt_prod  = 47'(front.tgt_num) * 47'(TGT_RECIP);
    assign ramp_prod = 33'(max_ext) * 33'(front.ramp_len);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else
        begin
            b_vld_reg <= in_vld;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_vld)
        begin
            b_mode_reg   <= front.mode;
            b_tau_reg    <= front.tau_c;
            b_target_reg <= tgt_prod[TGT_SHIFT+16:TGT_SHIFT];
            b_prod_reg   <= ramp_prod;
            b_weight_reg <= front.weight;
        end
    end

    assign x_prod = 50'(b_prod_reg) * 50'(b_weight_reg);

    always_comb
    begin
        case (b_mode_reg)
            MODE_CONTACT: c_tau_next = Q_ONE;
            MODE_TOUCH:   c_tau_next = (b_target_reg > b_tau_reg) ? b_target_reg : b_tau_reg;
            default:      c_tau_next = b_tau_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (b_vld_reg)
        begin
            c_tau_reg <= c_tau_next;
            // drop the low 15 bits; the half-unit rounding term folds into the divider
            c_xs_reg  <= x_prod[XS_W+14:15];
        end
    end

    assign vld      = c_vld_reg;
    assign tau_out  = c_tau_reg;
    assign xs       = c_xs_reg;
    assign occupied = b_vld_reg | c_vld_reg;

endmodule

// File: rtl/core/stte_div.sv
// Pipelined restoring divider, one quotient bit per stage: (xs + span) / (2*span).
// Carries the finished tau alongside. Depends on stte_pkg.

module stte_div
    import stte_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_vld,
    input  logic [16:0]     in_tau,
    input  logic [XS_W-1:0] xs,
    input  logic [15:0]     late_tau,
    output logic            vld,
    output logic [16:0]     tau_out,
    output logic [QUO_W-1:0] quo,
    output logic            occupied
);

    logic [16:0]       span;
    logic [17:0]       dvs;
    logic [QUO_W:0]    vld_reg;
    logic [REM_W-1:0]  rem_reg [0:QUO_W];
    logic [QUO_W-1:0]  quo_reg [0:QUO_W];
    logic [16:0]       tau_reg [0:QUO_W];

    assign span = calc_span(late_tau);
    assign dvs  = {span, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[QUO_W-1:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        if (in_vld)
        begin
            rem_reg[0] <= REM_W'(xs) + REM_W'(span);
            quo_reg[0] <= '0;
            tau_reg[0] <= in_tau;
        end
    end

    for (genvar k = 1; k <= QUO_W; k++)
    begin : g_stage
        logic [REM_W-1:0] trial;
        logic             ge;

        assign trial = REM_W'(dvs) << (QUO_W - k);
        assign ge    = rem_reg[k-1] >= trial;

        always_ff @(posedge clk)
        begin
            if (vld_reg[k-1])
            begin
                rem_reg[k] <= ge ? (rem_reg[k-1] - trial) : rem_reg[k-1];
                quo_reg[k] <= {quo_reg[k-1][QUO_W-2:0], ge};
                tau_reg[k] <= tau_reg[k-1];
            end
        end
    end

    assign vld      = vld_reg[QUO_W];
    assign tau_out  = tau_reg[QUO_W];
    assign quo      = quo_reg[QUO_W];
    assign occupied = |vld_reg;

endmodule

// File: rtl/core/swing_touchdown_tau_extension.sv
// Top level of the swing touchdown tau extension block: config registers and pipeline.
// Depends on stte_pkg, stte_front, stte_scale, stte_div.
//
//  channel   | handshake              | payload
//  ----------+------------------------+-------------------------------------------
//  request   | start / busy           | swing_active .. tau_in
//  result    | done (strobe)          | tau_out, extension_um
//  config    | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A request is taken on any cycle with start high; busy stays low, so one request per cycle.
// Each result passes through one decode stage, two multiply stages and a 17-stage divider
// (sum stage plus one quotient bit per stage). The receiver cannot stall; results flow out
// in request order with done high for one cycle. cfg_ready is high while no request is in
// flight or being taken. Reset clears valid bits and restores the register defaults.

module swing_touchdown_tau_extension
    import stte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        swing_active,
    input  logic        raw_contact,
    input  logic        state_valid,
    input  logic        has_diagnostics,
    input  logic        reset_requested,
    input  logic [16:0] fusion_trust,
    input  logic        has_fusion_record,
    input  logic [1:0]  contact_phase,
    input  logic [16:0] contact_confidence,
    input  logic signed [19:0] tau_in,
    output logic        done,
    output logic [16:0] tau_out,
    output logic [15:0] extension_um,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    localparam int PIPE_LAT = QUO_W + 4;

    logic [16:0] min_trust_reg;
    logic [15:0] late_tau_reg;
    logic [15:0] max_ext_reg;

    logic            req;
    logic            f_vld;
    front_t          f_data;
    logic            s_vld;
    logic [16:0]     s_tau;
    logic [XS_W-1:0] s_xs;
    logic            s_occ;
    logic            d_occ;

    assign busy = 1'b0;
    assign req  = start && !busy;
    assign cfg_ready = !(req || f_vld || s_occ || d_occ);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_trust_reg <= MIN_TRUST_RST;
            late_tau_reg  <= LATE_TAU_RST;
            max_ext_reg   <= MAX_EXT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MIN_TRUST: min_trust_reg <= cfg_data;
                CFG_LATE_TAU:  late_tau_reg  <= cfg_data[15:0];
                CFG_MAX_EXT:   max_ext_reg   <= cfg_data[15:0];
                default:       ;
            endcase
        end
    end

    stte_front u_front
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .req_valid          (req),
        .swing_active       (swing_active),
        .raw_contact        (raw_contact),
        .state_valid        (state_valid),
        .has_diagnostics    (has_diagnostics),
        .reset_requested    (reset_requested),
        .fusion_trust       (fusion_trust),
        .has_fusion_record  (has_fusion_record),
        .contact_phase      (contact_phase),
        .contact_confidence (contact_confidence),
        .tau_in             (tau_in),
        .min_trust          (min_trust_reg),
        .late_tau           (late_tau_reg),
        .vld                (f_vld),
        .front              (f_data)
    );

    stte_scale u_scale
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (f_vld),
        .front    (f_data),
        .max_ext  (max_ext_reg),
        .vld      (s_vld),
        .tau_out  (s_tau),
        .xs       (s_xs),
        .occupied (s_occ)
    );

    stte_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (s_vld),
        .in_tau   (s_tau),
        .xs       (s_xs),
        .late_tau (late_tau_reg),
        .vld      (done),
        .tau_out  (tau_out),
        .quo      (extension_um),
        .occupied (d_occ)
    );

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req |-> ##PIPE_LAT done)
        else $error("result strobe missing after request");

    a_tau_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (tau_out <= Q_ONE))
        else $error("tau_out above one");

    a_ext_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (extension_um <= max_ext_reg))
        else $error("extension above configured maximum");

    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !cfg_ready)
        else $error("config port open while a result is in flight");

endmodule

// File: tb/stte_leg_checker.sv
// Checker for the swing touchdown tau extension block: mirrors the config registers,
// predicts tau_out and extension_um per accepted request and compares them in order.
// Depends on stte_pkg for register indexes, phase codes and reset values.
`timescale 1ns / 1ps

module stte_leg_checker
    import stte_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               swing_active,
    input  logic               raw_contact,
    input  logic               state_valid,
    input  logic               has_diagnostics,
    input  logic               reset_requested,
    input  logic [16:0]        fusion_trust,
    input  logic               has_fusion_record,
    input  logic [1:0]         contact_phase,
    input  logic [16:0]        contact_confidence,
    input  logic signed [19:0] tau_in,
    input  logic               done,
    input  logic [16:0]        tau_out,
    input  logic [15:0]        extension_um,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [16:0]        cfg_data,
    output int                 fails,
    output int                 n_awaited
);

    typedef struct
    {
        logic [16:0] tau;
        logic [15:0] ext;
    } leg_result_t;

    leg_result_t awaited_legs[$];

    logic [16:0] min_trust_q;
    logic [15:0] late_tau_q;
    logic [15:0] max_ext_q;

    function automatic logic [15:0] extension_ramp(input int t, input longint unsigned w);
        longint unsigned span;
        longint unsigned ramp_d;
        longint unsigned den;
        span   = 65536 - longint'(late_tau_q);
        ramp_d = longint'(t) - longint'(late_tau_q);
        den    = span * 65536;
        if (ramp_d > span)
            ramp_d = span;
        extension_ramp = 16'((longint'(max_ext_q) * ramp_d * w + den / 2) / den);
    endfunction

    function automatic leg_result_t adjust_swing_leg(
        input logic               swing,
        input logic               contact,
        input logic               valid,
        input logic               diag,
        input logic               hard_reset,
        input logic [16:0]        trust,
        input logic               record,
        input logic [1:0]         phase_raw,
        input logic [16:0]        conf_raw,
        input logic signed [19:0] tau_raw
    );
        leg_result_t res;
        int          t;
        int          conf;
        int          tau_c;
        int          target;
        phase_t      ph;
        logic        trusted;
        t     = tau_raw;
        conf  = (conf_raw > Q_ONE) ? int'(Q_ONE) : int'(conf_raw);
        ph    = record ? phase_t'(phase_raw) : PH_SEARCH;
        tau_c = (t < 0) ? 0 : ((t > 65536) ? 65536 : t);
        trusted = valid && (!diag || (!hard_reset && trust >= min_trust_q));
        res.ext = '0;
        if (swing && trusted)
        begin
            if (contact)
                tau_c = 65536;
            else if (ph == PH_EXPECT || ph == PH_CAND)
            begin
                target = (92 * 65536 + 6 * conf + 50) / 100;
                if (target > tau_c)
                    tau_c = target;
                if (t >= int'(late_tau_q))
                    res.ext = extension_ramp(t, (conf > int'(EXT_CONF_FLOOR)) ?
                                             longint'(conf) : longint'(EXT_CONF_FLOOR));
            end
            else if (ph == PH_SEARCH)
            begin
                if (t >= int'(late_tau_q))
                    res.ext = extension_ramp(t, 65536);
            end
        end
        res.tau = 17'(tau_c);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        leg_result_t exp_leg;
        if (!rst_n)
        begin
            min_trust_q = MIN_TRUST_RST;
            late_tau_q  = LATE_TAU_RST;
            max_ext_q   = MAX_EXT_RST;
            awaited_legs.delete();
            n_awaited   = 0;
            fails       = 0;
        end
        else
        begin
            if (done)
            begin
                if (awaited_legs.size() == 0)
                begin
                    $display("%0t: unexpected result tau_out=%0d extension_um=%0d",
                             $time, tau_out, extension_um);
                    fails++;
                end
                else
                begin
                    exp_leg = awaited_legs.pop_front();
                    if (tau_out !== exp_leg.tau)
                    begin
                        $display("%0t: tau_out mismatch: expected %0d actual %0d",
                                 $time, exp_leg.tau, tau_out);
                        fails++;
                    end
                    if (extension_um !== exp_leg.ext)
                    begin
                        $display("%0t: extension_um mismatch: expected %0d actual %0d",
                                 $time, exp_leg.ext, extension_um);
                        fails++;
                    end
                end
            end
            if (start && !busy)
                awaited_legs.push_back(adjust_swing_leg(swing_active, raw_contact,
                    state_valid, has_diagnostics, reset_requested, fusion_trust,
                    has_fusion_record, contact_phase, contact_confidence, tau_in));
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MIN_TRUST: min_trust_q = cfg_data;
                    CFG_LATE_TAU:  late_tau_q  = cfg_data[15:0];
                    CFG_MAX_EXT:   max_ext_q   = cfg_data[15:0];
                    default: ;
                endcase
            end
            n_awaited = awaited_legs.size();
        end
    end

endmodule

// File: tb/tb_top.sv
// Testbench top for the swing touchdown tau extension block: clock, reset, config
// phases and leg requests; checking is done by stte_leg_checker. Depends on stte_pkg.
`timescale 1ns / 1ps

module tb_top;
    import stte_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               swing_active = 1'b0;
    logic               raw_contact = 1'b0;
    logic               state_valid = 1'b0;
    logic               has_diagnostics = 1'b0;
    logic               reset_requested = 1'b0;
    logic [16:0]        fusion_trust = '0;
    logic               has_fusion_record = 1'b0;
    logic [1:0]         contact_phase = PH_SEARCH;
    logic [16:0]        contact_confidence = '0;
    logic signed [19:0] tau_in = '0;
    logic               done;
    logic [16:0]        tau_out;
    logic [15:0]        extension_um;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = CFG_MIN_TRUST;
    logic [16:0]        cfg_data = '0;
    int                 fails;
    int                 n_awaited;

    int cur_min  = MIN_TRUST_RST;
    int cur_late = LATE_TAU_RST;
    int idle_pct = 0;

    swing_touchdown_tau_extension u_top (.*);

    stte_leg_checker u_checker (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic issue(input logic sw, ct, sv, hd, rr, input logic [16:0] mt,
                         input logic hf, input logic [1:0] ph, input logic [16:0] cc,
                         input int ti);
        start              <= 1'b1;
        swing_active       <= sw;
        raw_contact        <= ct;
        state_valid        <= sv;
        has_diagnostics    <= hd;
        reset_requested    <= rr;
        fusion_trust       <= mt;
        has_fusion_record  <= hf;
        contact_phase      <= ph;
        contact_confidence <= cc;
        tau_in             <= 20'(ti);
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic pause(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // drain the pipeline so that config writes land while the block is idle
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (n_awaited != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 17'(val);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input int mt, input int lt, input int mx);
        settle();
        write_reg(CFG_LATE_TAU, lt);
        write_reg(CFG_MAX_EXT, mx);
        write_reg(CFG_MIN_TRUST, mt);
        cur_min  = mt;
        cur_late = lt;
    endtask

    task automatic random_leg();
        int          tau;
        int          trust;
        int          conf;
        logic        hd;
        case ($urandom_range(0, 9))
            0:       tau = $urandom_range(0, 20'hFFFFF) - 524288;
            1:       tau = -$urandom_range(1, 3000);
            2, 3, 4, 5, 6:
                     tau = cur_late + $urandom_range(0, 66536 - cur_late) - 500;
            default: tau = $urandom_range(0, 70000);
        endcase
        case ($urandom_range(0, 5))
            0:       trust = $urandom_range(0, 17'h1FFFF);
            1:       trust = ($urandom_range(0, 1) != 0) ? 65536 : 0;
            2, 3:    trust = cur_min + $urandom_range(0, 6) - 3;
            default: trust = $urandom_range(0, 65536);
        endcase
        if (trust < 0)
            trust = 0;
        case ($urandom_range(0, 7))
            0:       conf = 0;
            1:       conf = 65536;
            2:       conf = $urandom_range(0, 17'h1FFFF);
            default: conf = $urandom_range(0, 65536);
        endcase
        hd = ($urandom_range(0, 1) != 0);
        issue($urandom_range(0, 9) != 0, $urandom_range(0, 6) == 0,
              $urandom_range(0, 9) != 0, hd, $urandom_range(0, 4) == 0,
              17'(trust), $urandom_range(0, 5) != 0, 2'($urandom_range(0, 3)),
              17'(conf), tau);
        if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct)
            pause($urandom_range(1, 7));
    endtask

    task automatic random_run(input int n, input logic quiet);
        for (int i = 0; i < n; i++)
        begin
            if (i % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 15;
                    default: idle_pct = 45;
                endcase
                if (quiet)
                    idle_pct = 0;
            end
            random_leg();
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed legs at the reset register values
        issue(0, 0, 0, 0, 0, 17'd0, 0, PH_SEARCH, 17'd0, 0);
        issue(1, 0, 1, 0, 0, 17'd0, 0, PH_SEARCH, 17'd0, 0);
        issue(1, 0, 1, 0, 0, 17'd0, 0, PH_SEARCH, 17'd0, -524288);
        issue(1, 0, 1, 0, 0, 17'd0, 0, PH_SEARCH, 17'd0, 524287);
        issue(1, 0, 1, 0, 0, 17'd0, 1, PH_SEARCH, 17'd0, -1);
        issue(1, 1, 1, 0, 0, 17'd0, 1, PH_EXPECT, 17'd30000, 60000);
        issue(1, 0, 1, 0, 0, 17'd0, 1, PH_STANCE, 17'd65536, 62000);
        issue(1, 0, 1, 0, 0, 17'd0, 1, PH_EXPECT, 17'd0, 0);
        issue(1, 0, 1, 0, 0, 17'd0, 1, PH_CAND, 17'd65536, 65536);
        pause(3);
        issue(1, 0, 1, 0, 0, 17'd0, 1, PH_CAND, 17'h1FFFF, 65000);
        issue(1, 0, 1, 0, 0, 17'd0, 0, PH_CAND, 17'd65536, 60000);
        issue(1, 0, 1, 1, 1, 17'd65536, 1, PH_EXPECT, 17'd40000, 60000);
        issue(1, 0, 1, 1, 0, MIN_TRUST_RST - 17'd1, 1, PH_EXPECT, 17'd40000, 60000);
        issue(1, 0, 1, 1, 0, MIN_TRUST_RST, 1, PH_EXPECT, 17'd40000, 60000);
        issue(1, 0, 1, 1, 0, 17'd65536, 1, PH_SEARCH, 17'd0, 60000);
        issue(1, 0, 1, 1, 0, 17'h1FFFF, 1, PH_CAND, 17'd22939, 65536);
        pause(1);
        issue(1, 1, 0, 0, 0, 17'd65536, 1, PH_EXPECT, 17'd65536, 60000);
        issue(0, 1, 1, 0, 0, 17'd65536, 1, PH_EXPECT, 17'd65536, 60000);
        issue(1, 0, 1, 0, 0, 17'd0, 1, PH_SEARCH, 17'd0, LATE_TAU_RST);
        issue(1, 0, 1, 0, 0, 17'd0, 1, PH_SEARCH, 17'd0, LATE_TAU_RST - 1);
        issue(1, 0, 1, 0, 0, 17'd0, 1, PH_EXPECT, 17'd1000, 65536);
        issue(1, 0, 1, 0, 0, 17'd0, 1, PH_SEARCH, 17'd0, 65537);
        pause(2);

        random_run(115, 1'b0);
        configure(0, 0, 65535);
        random_run(115, 1'b0);
        configure(65536, 65535, 0);
        random_run(115, 1'b0);
        configure(65535, 1, 1);
        random_run(115, 1'b0);
        configure($urandom_range(0, 65536), $urandom_range(0, 65535),
                  $urandom_range(0, 65535));
        random_run(115, 1'b0);
        configure($urandom_range(0, 65536), $urandom_range(0, 65535),
                  $urandom_range(0, 65535));
        random_run(115, 1'b0);
        configure(MIN_TRUST_RST, $urandom_range(40000, 65535), $urandom_range(0, 65535));
        random_run(115, 1'b1);

        settle();
        if (fails == 0 && n_awaited == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
